[design/sojb_pkg.sv]
// ============================================================================
// sojb_pkg
// Shared types, codes and defaults for the sequence-ordered jitter buffer.
// ============================================================================
package sojb_pkg;

    localparam int SOJB_DEPTH_DEF       = 16;
    localparam int SOJB_HANDLE_BITS_DEF = 8;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_DROP   = 2'd2,
        CMD_FLUSH  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_LATE  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] seq_number;
        logic [31:0] timestamp;
        logic [15:0] payload_size;
        logic [7:0]  payload_handle;
        logic [7:0]  drop_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_seq;
        logic [31:0] out_timestamp;
        logic [15:0] out_size;
        logic [7:0]  out_handle;
        logic [4:0]  fill_count;
        logic [31:0] newest_seq;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_COMMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        ACT_INSERT_POS,
        ACT_INSERT_FRONT,
        ACT_REJECT_FULL,
        ACT_REJECT_LATE,
        ACT_POP,
        ACT_POP_EMPTY,
        ACT_DROP,
        ACT_FLUSH
    } act_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_head;
        logic rd_prev;
        logic shift;
        logic commit;
        act_t act;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic data_gt;
        logic head_adj;
        logic out_free;
    } dp_stat_t;

endpackage

[design/sojb_if.sv]
// ============================================================================
// sojb_if
// Valid/ready channels for command items and result items.
// ============================================================================
interface sojb_in_if;
    import sojb_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sojb_out_if;
    import sojb_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/sojb_ctrl.sv]
// ============================================================================
// sojb_ctrl
// Command sequencer: decodes each item, runs the insert walk, triggers commit.
// ============================================================================
module sojb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sojb_pkg::dp_stat_t stat,
    output sojb_pkg::dp_cmd_t  cmd
);
    import sojb_pkg::*;

    ctrl_state_t state_reg, state_next;
    act_t        act_reg, act_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= ACT_FLUSH;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

    // Next state and pending action
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_INSERT:
                    begin
                        if (stat.full)
                        begin
                            act_next   = ACT_REJECT_FULL;
                            state_next = S_COMMIT;
                        end
                        else if (stat.empty)
                        begin
                            act_next   = ACT_INSERT_POS;
                            state_next = S_COMMIT;
                        end
                        else
                        begin
                            state_next = S_HEAD_RD;
                        end
                    end
                    CMD_POP:
                    begin
                        if (stat.empty)
                        begin
                            act_next   = ACT_POP_EMPTY;
                            state_next = S_COMMIT;
                        end
                        else
                        begin
                            state_next = S_HEAD_RD;
                        end
                    end
                    CMD_DROP:
                    begin
                        act_next   = ACT_DROP;
                        state_next = S_COMMIT;
                    end
                    CMD_FLUSH:
                    begin
                        act_next   = ACT_FLUSH;
                        state_next = S_COMMIT;
                    end
                endcase
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_CHK;
            end
            S_HEAD_CHK:
            begin
                priority if (stat.cmd == CMD_POP)
                begin
                    act_next   = ACT_POP;
                    state_next = S_COMMIT;
                end
                else if (stat.data_gt)
                begin
                    // Below every entry: only the immediate predecessor is kept
                    act_next   = stat.head_adj ? ACT_INSERT_FRONT : ACT_REJECT_LATE;
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (stat.data_gt)
                begin
                    state_next = S_WALK_RD;
                end
                else
                begin
                    act_next   = ACT_INSERT_POS;
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd         = '0;
        cmd.act     = act_reg;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_HEAD_RD:
            begin
                cmd.rd_head = 1'b1;
            end
            S_WALK_RD:
            begin
                cmd.rd_prev = 1'b1;
            end
            S_WALK_CHK:
            begin
                cmd.shift = stat.data_gt;
            end
            S_COMMIT:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                cmd.commit = 1'b0;
            end
        endcase
    end

endmodule

[design/sojb_datapath.sv]
// ============================================================================
// sojb_datapath
// Circular descriptor store, head/count/newest registers and result register.
// ============================================================================
module sojb_datapath #(
    parameter int DEPTH       = sojb_pkg::SOJB_DEPTH_DEF,
    parameter int HANDLE_BITS = sojb_pkg::SOJB_HANDLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sojb_pkg::in_item_t  in_data,
    output sojb_pkg::out_item_t out_data,
    output logic                out_valid,
    input  logic                out_ready,
    input  sojb_pkg::dp_cmd_t   cmd,
    output sojb_pkg::dp_stat_t  stat
);
    import sojb_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > 8) ? CW : 8;
    localparam int SW = IW + 2;
    localparam int EW = 80 + HANDLE_BITS;

    logic [EW-1:0] mem [DEPTH];

    in_item_t      item_reg;
    logic [CW-1:0] pos_reg;
    logic [EW-1:0] rd_data_reg;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   newest_reg, newest_next;
    logic          out_valid_reg;
    out_item_t     out_item_reg, result;

    logic [31:0]          rd_seq;
    logic [31:0]          rd_time;
    logic [15:0]          rd_size;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [HANDLE_BITS-1:0] in_handle;
    logic [EW-1:0]        new_entry;
    logic [IW-1:0]        head_dec;
    logic [IW-1:0]        pos_addr;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic [KW-1:0]        drop_ext, count_ext, drop_k;

    // Logical index to physical slot, one compare and subtract
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        begin
            sum = SW'(base) + SW'(off);
            if (sum >= SW'(DEPTH))
            begin
                sum = sum - SW'(DEPTH);
            end
            return sum[IW-1:0];
        end
    endfunction

    assign rd_seq    = rd_data_reg[EW-1 -: 32];
    assign rd_time   = rd_data_reg[EW-33 -: 32];
    assign rd_size   = rd_data_reg[HANDLE_BITS+15 -: 16];
    assign rd_handle = rd_data_reg[HANDLE_BITS-1:0];

    assign in_handle = HANDLE_BITS'(item_reg.payload_handle);
    assign new_entry = {item_reg.seq_number, item_reg.timestamp,
                        item_reg.payload_size, in_handle};

    assign head_dec = (head_reg == '0) ? IW'(DEPTH - 1) : (head_reg - IW'(1));
    assign pos_addr = wrap_add(head_reg, pos_reg);
    assign rd_addr  = cmd.rd_prev ? wrap_add(head_reg, pos_reg - CW'(1)) : head_reg;

    always_comb
    begin
        wr_en   = cmd.shift;
        wr_addr = pos_addr;
        wr_data = rd_data_reg;
        if (cmd.commit && (cmd.act == ACT_INSERT_POS))
        begin
            wr_en   = 1'b1;
            wr_data = new_entry;
        end
        else if (cmd.commit && (cmd.act == ACT_INSERT_FRONT))
        begin
            wr_en   = 1'b1;
            wr_addr = head_dec;
            wr_data = new_entry;
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_head || cmd.rd_prev)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign drop_ext  = KW'(item_reg.drop_count);
    assign count_ext = KW'(count_reg);
    assign drop_k    = (drop_ext < count_ext) ? drop_ext : count_ext;

    // Commit: next queue registers and result item
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        newest_next = newest_reg;
        result      = '0;
        result.status = STAT_DONE;
        unique case (cmd.act)
            ACT_INSERT_POS:
            begin
                count_next = count_reg + CW'(1);
                if (pos_reg == count_reg)
                begin
                    newest_next = item_reg.seq_number;
                end
            end
            ACT_INSERT_FRONT:
            begin
                head_next  = head_dec;
                count_next = count_reg + CW'(1);
            end
            ACT_REJECT_FULL:
            begin
                result.status     = STAT_FULL;
                result.out_handle = 8'(in_handle);
            end
            ACT_REJECT_LATE:
            begin
                result.status     = STAT_LATE;
                result.out_handle = 8'(in_handle);
            end
            ACT_POP:
            begin
                head_next            = wrap_add(head_reg, CW'(1));
                count_next           = count_reg - CW'(1);
                result.out_seq       = rd_seq;
                result.out_timestamp = rd_time;
                result.out_size      = rd_size;
                result.out_handle    = 8'(rd_handle);
            end
            ACT_POP_EMPTY:
            begin
                result.status = STAT_EMPTY;
            end
            ACT_DROP:
            begin
                head_next  = wrap_add(head_reg, CW'(drop_k));
                count_next = count_reg - CW'(drop_k);
            end
            ACT_FLUSH:
            begin
                count_next = '0;
            end
        endcase
        if (count_next == '0)
        begin
            newest_next = '0;
        end
        result.fill_count = 5'(count_next);
        result.newest_seq = newest_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            newest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                newest_reg    <= newest_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
            pos_reg  <= count_reg;
        end
        else if (cmd.shift)
        begin
            pos_reg <= pos_reg - CW'(1);
        end
        if (cmd.commit)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    assign stat.cmd      = cmd_t'(item_reg.command);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.data_gt  = (rd_seq > item_reg.seq_number);
    assign stat.head_adj = ((rd_seq - item_reg.seq_number) == 32'd1);
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

[design/sequence_ordered_jitter_buffer_top.sv]
// ============================================================================
// sequence_ordered_jitter_buffer_top
// Packet descriptor queue kept sorted by sequence number.
// ============================================================================
// Usage:
//   in_ch carries one command per transfer: insert a descriptor, pop the
//   head, drop up to drop_count heads, or flush. out_ch returns exactly one
//   result per command, in command order, with status, the popped descriptor
//   (or the handle of a refused insert to free), fill count and tail number.
// Steps (accept to result):
//   flush, drop, empty pop, full or empty insert: decode, commit
//   pop, late insert, front insert: decode, head read, head check, commit
//   other inserts: decode, head read and check, walk steps, commit
//   The next command is taken in the cycle after a result is loaded.
//   The insert walk steps back from the tail through the single read port
//   of the store: per entry one read, one compare and, if needed, one move.
// Reset: the queue comes up empty and no result is pending; the store
//   contents are not cleared, since only held entries are ever read.
// Stall: the result sits in an output register while the receiver holds
//   ready low; the next command is still taken and worked on, and waits at
//   its commit until the output register is free.
module sequence_ordered_jitter_buffer_top #(
    parameter int DEPTH       = sojb_pkg::SOJB_DEPTH_DEF,
    parameter int HANDLE_BITS = sojb_pkg::SOJB_HANDLE_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    sojb_in_if.sink   in_ch,
    sojb_out_if.source out_ch
);
    import sojb_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Sequencer: owns the input handshake and orders the datapath steps
    sojb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // Store, queue pointers and the result register
    sojb_datapath #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_ch.data),
        .out_data  (out_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

endmodule

[design/sojb_checker.sv]
// ============================================================================
// sojb_checker
// Port-level checks on the jitter buffer, attached to the top level by bind.
// ============================================================================
module sojb_checker #(
    parameter int DEPTH = sojb_pkg::SOJB_DEPTH_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input sojb_pkg::out_item_t out_data
);
    import sojb_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One command at a time: no transfer right after an accepted one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a transfer");

    // Empty queue reports no tail number
    a_empty_newest: assert property (@(posedge clk) disable iff (!rst_n)
        (DEPTH < 32) && out_valid && (out_data.fill_count == 5'd0)
        |-> (out_data.newest_seq == 32'd0))
        else $error("tail number on empty queue");

    // Pop on empty queue carries nothing
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STAT_EMPTY)
        |-> (out_data.fill_count == 5'd0) && (out_data.out_seq == 32'd0)
            && (out_data.out_handle == 8'd0))
        else $error("empty pop with data");

endmodule

bind sequence_ordered_jitter_buffer_top sojb_checker #(
    .DEPTH (DEPTH)
) u_sojb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
